### src/bmp_stream_pixel_decoder_macros.svh
// Assertion macros used by the top-level decoder file.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef BMP_STREAM_PIXEL_DECODER_MACROS_SVH
`define BMP_STREAM_PIXEL_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bmp_dec_pkg.sv
`timescale 1ns / 1ps

package bmp_dec_pkg;

  // Field widths of the two channels.
  localparam int STATUS_W = 3;
  localparam int COORD_W  = 12;
  localparam int CHAN_W   = 8;

  // Result codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_PIXEL     = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_BAD_SIG   = 3'd2,
    ST_HDR_SIZE  = 3'd3,
    ST_COMPRESS  = 3'd4,
    ST_DEPTH     = 3'd5,
    ST_TRUNCATED = 3'd6,
    ST_TOO_LARGE = 3'd7
  } status_t;

  // One result item.
  typedef struct packed {
    status_t             status;
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [CHAN_W-1:0]   alpha;
    logic                last_pixel;
  } result_t;

  // File format constants.
  localparam logic [15:0] SIGNATURE      = 16'h4D42;
  localparam logic [31:0] HLEN_40        = 32'd40;
  localparam logic [31:0] HLEN_52        = 32'd52;
  localparam logic [31:0] HLEN_56        = 32'd56;
  localparam logic [31:0] COMP_RGB       = 32'd0;
  localparam logic [31:0] COMP_BITFIELDS = 32'd3;
  localparam logic [15:0] BPP_24         = 16'd24;
  localparam logic [15:0] BPP_32         = 16'd32;
  localparam logic [7:0]  ALPHA_OPAQUE   = 8'd255;

endpackage

### src/bmp_dec_if.sv
`timescale 1ns / 1ps

// Byte input channel.
interface bmp_dec_in_if import bmp_dec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [CHAN_W-1:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

// Result channel.
interface bmp_dec_out_if import bmp_dec_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STATUS_W-1:0] status;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;
  logic [CHAN_W-1:0]  alpha;
  logic               last_pixel;

  modport source (output valid, output status, output pixel_x, output pixel_y,
                  output red, output green, output blue, output alpha,
                  output last_pixel, input ready);
  modport sink   (input valid, input status, input pixel_x, input pixel_y,
                  input red, input green, input blue, input alpha,
                  input last_pixel, output ready);
endinterface

### src/bmp_stream_pixel_decoder.sv
// A result is pushed into the result queue as its byte is accepted, behind earlier results.
// Throughput: one byte per cycle; the header parser and pixel unpacker update once per byte,
// and a two-entry result queue lets input flow while a result waits and stalls it when full.
// Reset (rst_n low, synchronous): parser returns to the file header phase, queue empties.
// An end-of-file item restarts the parser the same way, and reports unless it was halted.
`timescale 1ns / 1ps

`include "bmp_stream_pixel_decoder_macros.svh"

module bmp_stream_pixel_decoder import bmp_dec_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  bmp_dec_in_if.sink    in_ch,
  bmp_dec_out_if.source out_ch
);

  logic    accept;
  logic    full;
  logic    res_valid;
  result_t res;
  logic    q_valid;
  result_t q_data;

  // Input handshake: take a byte whenever the result queue has room.
  assign in_ch.ready = ~full;
  assign accept      = in_ch.valid && in_ch.ready;

  bmp_dec_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_func   (in_ch.func),
    .in_byte   (in_ch.data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  bmp_dec_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (q_valid),
    .out_ready (out_ch.ready),
    .out_data  (q_data)
  );

  // Result channel.
  assign out_ch.valid      = q_valid;
  assign out_ch.status     = q_data.status;
  assign out_ch.pixel_x    = q_data.pixel_x;
  assign out_ch.pixel_y    = q_data.pixel_y;
  assign out_ch.red        = q_data.red;
  assign out_ch.green      = q_data.green;
  assign out_ch.blue       = q_data.blue;
  assign out_ch.alpha      = q_data.alpha;
  assign out_ch.last_pixel = q_data.last_pixel;

  // Checks.
  `BMP_ASSERT_NOW(a_full_has_output, !in_ch.ready, out_ch.valid, "queue full without output")
  `BMP_ASSERT_NEXT(a_full_holds, !in_ch.ready && !out_ch.ready, !in_ch.ready, "queue lost entry")
  `BMP_ASSERT_NOW(a_status_fields_zero, out_ch.valid && out_ch.status != ST_PIXEL,
    out_ch.pixel_x == '0 && out_ch.pixel_y == '0 && out_ch.alpha == '0 &&
    out_ch.last_pixel == 1'b0, "status item carries pixel data")
  `BMP_ASSERT_NOW(a_accept_no_overflow, res_valid, !full, "result pushed into full queue")

endmodule

### src/bmp_dec_core.sv
`timescale 1ns / 1ps

module bmp_dec_core import bmp_dec_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              in_func,
  input  logic [CHAN_W-1:0] in_byte,
  output logic              res_valid,
  output result_t           res
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [7:0] {
    PH_FILE  = 8'b0000_0001,
    PH_ISIZE = 8'b0000_0010,
    PH_IBODY = 8'b0000_0100,
    PH_SKIP  = 8'b0000_1000,
    PH_PIXEL = 8'b0001_0000,
    PH_PAD   = 8'b0010_0000,
    PH_DONE  = 8'b0100_0000,
    PH_HALT  = 8'b1000_0000
  } phase_t;

  // Replace one byte lane of a 32-bit word.
  function automatic logic [31:0] put_byte32(input logic [31:0] word,
                                             input logic [1:0] lane,
                                             input logic [7:0] b);
    logic [31:0] w;
    w = word;
    w[lane*8 +: 8] = b;
    return w;
  endfunction

  phase_t        phase_r, phase_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic          sig_bad_r, sig_bad_nxt;
  logic [31:0]   offset_r, offset_nxt;
  logic [31:0]   hlen_r, hlen_nxt;
  logic [31:0]   width_raw_r, width_raw_nxt;
  logic [31:0]   height_raw_r, height_raw_nxt;
  logic [15:0]   bits_r, bits_nxt;
  logic [31:0]   comp_r, comp_nxt;
  logic [RW-1:0] height_r, height_nxt;
  logic          bottom_up_r, bottom_up_nxt;
  logic          four_r, four_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [1:0]    bip_r, bip_nxt;
  logic [1:0]    pad_r, pad_nxt;
  logic [23:0]   partial_r, partial_nxt;

  logic [31:0]   pos_inc;
  logic [1:0]    lane_a;
  logic [31:0]   hlen_full;
  logic [31:0]   h_mag;
  logic [CW-1:0] width_c;
  logic [CW-1:0] col_p1;
  logic [RW-1:0] row_p1;
  logic [23:0]   cur_pix;
  logic [7:0]    alpha_c;
  logic [1:0]    last_byte;
  logic [31:0]   x_full;
  logic [31:0]   y_full;

  // Header field helpers.
  assign pos_inc   = (pos_r == 32'hFFFF_FFFF) ? pos_r : pos_r + 32'd1;
  assign lane_a    = pos_r[1:0] + 2'd2;
  assign hlen_full = put_byte32(hlen_r, lane_a, in_byte);
  assign h_mag     = height_raw_r[31] ? (~height_raw_r + 32'd1) : height_raw_r;
  assign width_c   = width_raw_r[CW-1:0];
  assign col_p1    = col_r + CW'(1);
  assign row_p1    = row_r + RW'(1);
  assign last_byte = four_r ? 2'd3 : 2'd2;
  assign x_full    = 32'(col_r);
  assign y_full    = bottom_up_r ? (32'(height_r) - 32'd1 - 32'(row_r)) : 32'(row_r);

  // Current pixel with the incoming byte merged in.
  always_comb begin
    cur_pix = partial_r;
    alpha_c = ALPHA_OPAQUE;
    if (bip_r == 2'd3) begin
      alpha_c = in_byte;
    end else begin
      cur_pix[bip_r*8 +: 8] = in_byte;
    end
  end

  // Next state and result for the accepted item.
  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    sig_bad_nxt    = sig_bad_r;
    offset_nxt     = offset_r;
    hlen_nxt       = hlen_r;
    width_raw_nxt  = width_raw_r;
    height_raw_nxt = height_raw_r;
    bits_nxt       = bits_r;
    comp_nxt       = comp_r;
    height_nxt     = height_r;
    bottom_up_nxt  = bottom_up_r;
    four_nxt       = four_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    bip_nxt        = bip_r;
    pad_nxt        = pad_r;
    partial_nxt    = partial_r;
    res_valid      = 1'b0;
    res            = '0;

    if (accept && in_func) begin
      // End of file: report unless halted, and return to the reset state.
      if (phase_r == PH_DONE) begin
        res_valid  = 1'b1;
        res.status = ST_COMPLETE;
      end else if (phase_r != PH_HALT) begin
        res_valid  = 1'b1;
        res.status = ST_TRUNCATED;
      end
      phase_nxt      = PH_FILE;
      pos_nxt        = '0;
      sig_bad_nxt    = 1'b0;
      offset_nxt     = '0;
      hlen_nxt       = '0;
      width_raw_nxt  = '0;
      height_raw_nxt = '0;
      bits_nxt       = '0;
      comp_nxt       = '0;
      height_nxt     = '0;
      bottom_up_nxt  = 1'b0;
      four_nxt       = 1'b0;
      col_nxt        = '0;
      row_nxt        = '0;
      bip_nxt        = '0;
      pad_nxt        = '0;
      partial_nxt    = '0;
    end else if (accept) begin
      pos_nxt = pos_inc;
      case (phase_r)
        PH_FILE: begin
          if ((pos_r == 32'd0 && in_byte != SIGNATURE[7:0]) ||
              (pos_r == 32'd1 && in_byte != SIGNATURE[15:8])) begin
            sig_bad_nxt = 1'b1;
          end
          if (pos_r >= 32'd10 && pos_r <= 32'd13) begin
            offset_nxt = put_byte32(offset_r, lane_a, in_byte);
          end
          if (pos_r >= 32'd13) begin
            if (sig_bad_nxt) begin
              phase_nxt  = PH_HALT;
              res_valid  = 1'b1;
              res.status = ST_BAD_SIG;
            end else begin
              phase_nxt = PH_ISIZE;
            end
          end
        end
        PH_ISIZE: begin
          hlen_nxt = hlen_full;
          if (pos_r >= 32'd17) begin
            if (hlen_full == HLEN_40 || hlen_full == HLEN_52 || hlen_full == HLEN_56) begin
              phase_nxt = PH_IBODY;
            end else begin
              phase_nxt  = PH_HALT;
              res_valid  = 1'b1;
              res.status = ST_HDR_SIZE;
            end
          end
        end
        PH_IBODY: begin
          if (pos_r >= 32'd18 && pos_r <= 32'd21) begin
            width_raw_nxt = put_byte32(width_raw_r, lane_a, in_byte);
          end else if (pos_r >= 32'd22 && pos_r <= 32'd25) begin
            height_raw_nxt = put_byte32(height_raw_r, lane_a, in_byte);
          end else if (pos_r == 32'd28 || pos_r == 32'd29) begin
            bits_nxt[pos_r[0]*8 +: 8] = in_byte;
          end else if (pos_r >= 32'd30 && pos_r <= 32'd33) begin
            comp_nxt = put_byte32(comp_r, lane_a, in_byte);
          end
          // Header complete: judge compression, depth and size in turn.
          if (pos_r >= 32'd13 + hlen_r) begin
            if (comp_r != COMP_RGB && comp_r != COMP_BITFIELDS) begin
              phase_nxt  = PH_HALT;
              res_valid  = 1'b1;
              res.status = ST_COMPRESS;
            end else if (bits_r != BPP_24 && bits_r != BPP_32) begin
              phase_nxt  = PH_HALT;
              res_valid  = 1'b1;
              res.status = ST_DEPTH;
            end else if (width_raw_r > 32'(MAX_WIDTH) || h_mag > 32'(MAX_HEIGHT)) begin
              phase_nxt  = PH_HALT;
              res_valid  = 1'b1;
              res.status = ST_TOO_LARGE;
            end else begin
              height_nxt    = h_mag[RW-1:0];
              bottom_up_nxt = ~height_raw_r[31];
              four_nxt      = (bits_r == BPP_32);
              if (width_raw_r == 32'd0 || h_mag == 32'd0) begin
                phase_nxt = PH_DONE;
              end else if (pos_inc < offset_r) begin
                phase_nxt = PH_SKIP;
              end else begin
                phase_nxt = PH_PIXEL;
              end
            end
          end
        end
        PH_SKIP: begin
          if (pos_inc >= offset_r) begin
            phase_nxt = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          if (bip_r != last_byte) begin
            partial_nxt = cur_pix;
            bip_nxt     = bip_r + 2'd1;
          end else begin
            // Pixel complete: emit it and advance the raster position.
            res_valid      = 1'b1;
            res.status     = ST_PIXEL;
            res.pixel_x    = x_full[COORD_W-1:0];
            res.pixel_y    = y_full[COORD_W-1:0];
            res.red        = cur_pix[23:16];
            res.green      = cur_pix[15:8];
            res.blue       = cur_pix[7:0];
            res.alpha      = alpha_c;
            res.last_pixel = (col_p1 == width_c) && (row_p1 == height_r);
            partial_nxt    = '0;
            bip_nxt        = '0;
            if (col_p1 >= width_c) begin
              col_nxt = '0;
              row_nxt = row_p1;
              pad_nxt = four_r ? 2'd0 : width_raw_r[1:0];
              if (!four_r && width_raw_r[1:0] != 2'd0) begin
                phase_nxt = PH_PAD;
              end else if (row_p1 == height_r) begin
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_PIXEL;
              end
            end else begin
              col_nxt = col_p1;
            end
          end
        end
        PH_PAD: begin
          pad_nxt = pad_r - 2'd1;
          if (pad_r == 2'd1) begin
            phase_nxt = (row_r == height_r) ? PH_DONE : PH_PIXEL;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FILE;
      pos_r        <= '0;
      sig_bad_r    <= 1'b0;
      offset_r     <= '0;
      hlen_r       <= '0;
      width_raw_r  <= '0;
      height_raw_r <= '0;
      bits_r       <= '0;
      comp_r       <= '0;
      height_r     <= '0;
      bottom_up_r  <= 1'b0;
      four_r       <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      bip_r        <= '0;
      pad_r        <= '0;
      partial_r    <= '0;
    end else begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      sig_bad_r    <= sig_bad_nxt;
      offset_r     <= offset_nxt;
      hlen_r       <= hlen_nxt;
      width_raw_r  <= width_raw_nxt;
      height_raw_r <= height_raw_nxt;
      bits_r       <= bits_nxt;
      comp_r       <= comp_nxt;
      height_r     <= height_nxt;
      bottom_up_r  <= bottom_up_nxt;
      four_r       <= four_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      bip_r        <= bip_nxt;
      pad_r        <= pad_nxt;
      partial_r    <= partial_nxt;
    end
  end

endmodule

### src/bmp_dec_obuf.sv
`timescale 1ns / 1ps

module bmp_dec_obuf import bmp_dec_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  // Two-entry result queue: the parser keeps running while one result waits.
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### test/bmp_stream_pixel_decoder_tb.sv
`timescale 1ns / 1ps

module bmp_stream_pixel_decoder_tb import bmp_dec_pkg::*; ();

  localparam logic [31:0] MAX_WIDTH  = 32'd4096;
  localparam logic [31:0] MAX_HEIGHT = 32'd4096;
  localparam int          LIMIT_NS   = 100_000_000;
  localparam int          RANDOM_ITEMS = 1750;

  // Parser stages of the decoder as tracked by the predictor.
  typedef enum logic [2:0] {
    S_FILE_HDR,
    S_INFO_SIZE,
    S_INFO_BODY,
    S_SKIP,
    S_PIXELS,
    S_ROW_PAD,
    S_DONE,
    S_HALTED
  } parse_stage_t;

  // Kinds of generated files; noise is kept last.
  typedef enum int {
    F_GOOD,
    F_TRUNC,
    F_TALL,
    F_WIDE,
    F_EMPTY_IMG,
    F_BAD_SIG,
    F_BAD_HLEN,
    F_BAD_COMP,
    F_BAD_DEPTH,
    F_TOO_LARGE,
    F_NOISE
  } file_kind_t;

  typedef struct packed {
    logic       eof;
    logic [7:0] data;
  } byte_item_t;

  logic clk;
  logic rst_n;

  bmp_dec_in_if  in_if ();
  bmp_dec_out_if out_if ();

  bmp_stream_pixel_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // Stimulus and checking stores.
  byte_item_t file_bytes_q[$];
  result_t    predicted_results[$];
  logic [7:0] bmp_image[$];

  int queued_count   = 0;
  int accepted_count = 0;
  int small_items    = 0;
  int files_sent     = 0;
  int error_count    = 0;
  int results_seen   = 0;
  int status_seen[8];
  logic byte_taken   = 1'b0;

  // Idle bookkeeping for both channels.
  int send_gap  = 0;
  int send_calm = 0;
  int recv_hold = 0;
  int recv_calm = 0;

  // Predictor state.
  parse_stage_t stage;
  logic [31:0]  file_pos;
  logic [31:0]  info_len;
  logic [31:0]  data_offset;
  logic [31:0]  img_width;
  logic [31:0]  img_height;
  logic         rows_up;
  logic         px_bytes4;
  logic [31:0]  col;
  logic [31:0]  row;
  logic [1:0]   px_byte;
  logic [1:0]   pad_left;
  logic [23:0]  px_acc;
  logic         sig_wrong;
  logic [15:0]  depth;
  logic [31:0]  comp_code;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #(LIMIT_NS);
    $display("bmp_stream_pixel_decoder verification failed");
    $finish;
  end

  function void reset_parser();
    stage       = S_FILE_HDR;
    file_pos    = '0;
    info_len    = '0;
    data_offset = '0;
    img_width   = '0;
    img_height  = '0;
    rows_up     = 1'b0;
    px_bytes4   = 1'b0;
    col         = '0;
    row         = '0;
    px_byte     = '0;
    pad_left    = '0;
    px_acc      = '0;
    sig_wrong   = 1'b0;
    depth       = '0;
    comp_code   = '0;
  endfunction

  function void push_status(status_t st);
    result_t r;
    r = '0;
    r.status = st;
    predicted_results.push_back(r);
  endfunction

  function void halt_with(status_t st);
    stage = S_HALTED;
    push_status(st);
  endfunction

  // Advances the predicted parser by one accepted item.
  function void decode_byte(logic eof, logic [7:0] b);
    logic [31:0] pos;
    logic [31:0] nxt;
    logic [31:0] mag;
    logic [31:0] y;
    logic [1:0]  last_idx;
    logic [7:0]  a;
    result_t     r;
    pos = file_pos;
    nxt = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
    if (eof) begin
      if (stage == S_DONE) push_status(ST_COMPLETE);
      else if (stage != S_HALTED) push_status(ST_TRUNCATED);
      reset_parser();
      return;
    end
    file_pos = nxt;
    case (stage)
      S_FILE_HDR: begin
        if ((pos == 0 && b != SIGNATURE[7:0]) || (pos == 1 && b != SIGNATURE[15:8]))
          sig_wrong = 1'b1;
        if (pos >= 10 && pos <= 13) data_offset |= {24'd0, b} << (8 * (pos - 10));
        if (pos >= 13) begin
          if (sig_wrong) halt_with(ST_BAD_SIG);
          else stage = S_INFO_SIZE;
        end
      end
      S_INFO_SIZE: begin
        info_len |= {24'd0, b} << (8 * (pos - 14));
        if (pos >= 17) begin
          if (info_len == HLEN_40 || info_len == HLEN_52 || info_len == HLEN_56)
            stage = S_INFO_BODY;
          else
            halt_with(ST_HDR_SIZE);
        end
      end
      S_INFO_BODY: begin
        if (pos >= 18 && pos <= 21) img_width |= {24'd0, b} << (8 * (pos - 18));
        else if (pos >= 22 && pos <= 25) img_height |= {24'd0, b} << (8 * (pos - 22));
        else if (pos == 28 || pos == 29) depth |= {8'd0, b} << (8 * (pos - 28));
        else if (pos >= 30 && pos <= 33) comp_code |= {24'd0, b} << (8 * (pos - 30));
        // Checks run in a fixed order once the last info header byte is in.
        if (pos >= 32'd13 + info_len) begin
          if (comp_code != COMP_RGB && comp_code != COMP_BITFIELDS) begin
            halt_with(ST_COMPRESS);
          end else if (depth != BPP_24 && depth != BPP_32) begin
            halt_with(ST_DEPTH);
          end else begin
            rows_up = !img_height[31];
            mag = rows_up ? img_height : -img_height;
            if (img_width > MAX_WIDTH || mag > MAX_HEIGHT) begin
              halt_with(ST_TOO_LARGE);
            end else begin
              img_height = mag;
              px_bytes4 = (depth == BPP_32);
              if (img_width == 0 || img_height == 0) stage = S_DONE;
              else if (nxt < data_offset) stage = S_SKIP;
              else stage = S_PIXELS;
            end
          end
        end
      end
      S_SKIP: begin
        if (nxt >= data_offset) stage = S_PIXELS;
      end
      S_PIXELS: begin
        last_idx = px_bytes4 ? 2'd3 : 2'd2;
        a = ALPHA_OPAQUE;
        if (px_byte < 2'd3) px_acc |= {16'd0, b} << (8 * px_byte);
        else a = b;
        if (px_byte < last_idx) begin
          px_byte++;
        end else begin
          // Stream order is blue, green, red, then alpha for 32-bit pixels.
          px_byte = '0;
          y = rows_up ? img_height - 32'd1 - row : row;
          r = '0;
          r.status     = ST_PIXEL;
          r.pixel_x    = col[COORD_W-1:0];
          r.pixel_y    = y[COORD_W-1:0];
          r.red        = px_acc[23:16];
          r.green      = px_acc[15:8];
          r.blue       = px_acc[7:0];
          r.alpha      = a;
          r.last_pixel = (col + 32'd1 == img_width) && (row + 32'd1 == img_height);
          predicted_results.push_back(r);
          px_acc = '0;
          col++;
          if (col >= img_width) begin
            col = '0;
            row++;
            pad_left = px_bytes4 ? 2'd0 : img_width[1:0];
            if (pad_left != 0) stage = S_ROW_PAD;
            else stage = (row == img_height) ? S_DONE : S_PIXELS;
          end
        end
      end
      S_ROW_PAD: begin
        if (pad_left > 0) pad_left--;
        if (pad_left == 0) stage = (row == img_height) ? S_DONE : S_PIXELS;
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int idle_length(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Byte driver: changes inputs on the falling edge.
  always @(negedge clk) begin
    byte_item_t item;
    if (!rst_n) begin
      in_if.valid     <= 1'b0;
      in_if.func      <= 1'b0;
      in_if.data_byte <= '0;
      send_gap = 0;
    end else if (in_if.valid && !byte_taken) begin
      // Hold the current item until it is taken.
    end else if (send_gap != 0) begin
      in_if.valid <= 1'b0;
      send_gap--;
    end else if (file_bytes_q.size() != 0) begin
      item = file_bytes_q.pop_front();
      in_if.valid     <= 1'b1;
      in_if.func      <= item.eof;
      in_if.data_byte <= item.data;
      send_gap = idle_length(send_calm);
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Result receiver: random stalls on ready.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_hold = 0;
    end else if (recv_hold != 0) begin
      out_if.ready <= 1'b0;
      recv_hold--;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_hold = idle_length(recv_calm);
    end
  end

  // Monitor: predicts on each taken item and checks each delivered result.
  always @(posedge clk) begin
    result_t want;
    byte_taken <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      decode_byte(in_if.func, in_if.data_byte);
      accepted_count++;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      status_seen[out_if.status]++;
      if (predicted_results.size() == 0) begin
        $error("result with status %0d arrived with nothing predicted", out_if.status);
        error_count++;
      end else begin
        want = predicted_results.pop_front();
        check_field("status", want.status, out_if.status);
        check_field("pixel_x", want.pixel_x, out_if.pixel_x);
        check_field("pixel_y", want.pixel_y, out_if.pixel_y);
        check_field("red", want.red, out_if.red);
        check_field("green", want.green, out_if.green);
        check_field("blue", want.blue, out_if.blue);
        check_field("alpha", want.alpha, out_if.alpha);
        check_field("last_pixel", want.last_pixel, out_if.last_pixel);
      end
    end
  end

  task automatic queue_item(logic eof, logic [7:0] data);
    file_bytes_q.push_back('{eof: eof, data: data});
    queued_count++;
  endtask

  function void append_le(logic [31:0] value, int count);
    for (int i = 0; i < count; i++) bmp_image.push_back(value[8*i +: 8]);
  endfunction

  function void append_random(int count);
    for (int i = 0; i < count; i++) bmp_image.push_back(8'($urandom));
  endfunction

  // Waits until every queued item is taken and every predicted result is back.
  task automatic wait_idle();
    while (accepted_count != queued_count || predicted_results.size() != 0)
      @(posedge clk);
  endtask

  function automatic file_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return F_GOOD;
    if (r < 60) return F_TRUNC;
    if (r < 62) return F_TALL;
    if (r < 65) return F_EMPTY_IMG;
    if (r < 70) return F_BAD_SIG;
    if (r < 76) return F_BAD_HLEN;
    if (r < 82) return F_BAD_COMP;
    if (r < 88) return F_BAD_DEPTH;
    if (r < 94) return F_TOO_LARGE;
    return F_NOISE;
  endfunction

  // Builds one file of the given kind and queues it, followed by end of file.
  task automatic send_file(file_kind_t kind);
    logic [31:0] hlen;
    logic [31:0] offset;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] comp;
    logic [31:0] body_end;
    logic [31:0] mag;
    logic [15:0] bpp;
    logic [7:0]  sig_lo;
    logic [7:0]  sig_hi;
    logic        far_offset;
    int          px_size;
    int          row_size;
    int          pix_len;
    int          total;
    int          cut;
    bmp_image.delete();
    if (kind == F_NOISE) begin
      append_random($urandom_range(0, 40));
    end else begin
      // Signature, corrupted in one or both bytes for the bad-signature kind.
      sig_lo = SIGNATURE[7:0];
      sig_hi = SIGNATURE[15:8];
      if (kind == F_BAD_SIG) begin
        case ($urandom_range(0, 2))
          0: sig_lo = 8'($urandom);
          1: sig_hi = 8'($urandom);
          default: begin
            sig_lo = 8'($urandom);
            sig_hi = 8'($urandom);
          end
        endcase
        if (sig_lo == SIGNATURE[7:0] && sig_hi == SIGNATURE[15:8]) sig_hi ^= 8'h80;
      end

      case ($urandom_range(0, 2))
        0: hlen = HLEN_40;
        1: hlen = HLEN_52;
        default: hlen = HLEN_56;
      endcase
      if (kind == F_BAD_HLEN) begin
        case ($urandom_range(0, 4))
          0: hlen = 32'd0;
          1: hlen = 32'd39;
          2: hlen = 32'd41;
          3: hlen = 32'd124;
          default: hlen = $urandom;
        endcase
        if (hlen == HLEN_40 || hlen == HLEN_52 || hlen == HLEN_56) hlen++;
      end

      // Small images by default, top-down about half the time.
      width  = $urandom_range(1, 7);
      height = $urandom_range(1, 5);
      if ($urandom_range(0, 1)) height = -height;
      bpp  = $urandom_range(0, 1) ? BPP_32 : BPP_24;
      comp = $urandom_range(0, 1) ? COMP_BITFIELDS : COMP_RGB;
      case (kind)
        F_TALL: begin
          width  = $urandom_range(1, 3);
          height = $urandom_range(0, 1) ? 32'd4096 : -32'd4096;
        end
        F_WIDE: begin
          width  = 32'd4096;
          height = $urandom_range(0, 1) ? 32'd1 : -32'd1;
          bpp    = BPP_24;
        end
        F_EMPTY_IMG: begin
          if ($urandom_range(0, 1)) width = '0;
          else height = '0;
        end
        F_BAD_COMP: begin
          case ($urandom_range(0, 3))
            0: comp = 32'd1;
            1: comp = 32'd2;
            2: comp = 32'hFFFF_FFFF;
            default: comp = $urandom;
          endcase
          if (comp == COMP_RGB || comp == COMP_BITFIELDS) comp++;
          // Depth may be bad too; compression is judged first.
          bpp = 16'($urandom);
        end
        F_BAD_DEPTH: begin
          case ($urandom_range(0, 3))
            0: bpp = 16'd0;
            1: bpp = 16'd8;
            2: bpp = 16'd16;
            default: bpp = 16'($urandom);
          endcase
          if (bpp == BPP_24 || bpp == BPP_32) bpp++;
        end
        F_TOO_LARGE: begin
          case ($urandom_range(0, 4))
            0: width  = 32'd4097 + $urandom_range(0, 2000);
            1: width  = $urandom | 32'h8000_0000;
            2: height = 32'd4097 + $urandom_range(0, 2000);
            3: height = -(32'd4097 + $urandom_range(0, 2000));
            default: height = 32'h8000_0000;
          endcase
        end
        default: ;
      endcase

      // Pixel offset: at the header end, a few bytes past it, or below it.
      body_end = 32'd14 + hlen;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: offset = body_end;
        5, 6, 7: offset = body_end + $urandom_range(1, 6);
        default: offset = $urandom_range(0, body_end - 1);
      endcase
      far_offset = (kind == F_TRUNC) && ($urandom_range(0, 19) == 0);
      if (far_offset) offset = $urandom | 32'h0100_0000;

      append_le({sig_hi, sig_lo}, 2);
      append_random(8);
      append_le(offset, 4);
      append_le(hlen, 4);
      if (kind == F_BAD_SIG || kind == F_BAD_HLEN) begin
        append_random($urandom_range(0, 6));
      end else begin
        append_le(width, 4);
        append_le(height, 4);
        append_random(2);
        append_le({16'd0, bpp}, 2);
        append_le(comp, 4);
        append_random(hlen - 32'd20);
        if (kind == F_BAD_COMP || kind == F_BAD_DEPTH || kind == F_TOO_LARGE) begin
          append_random($urandom_range(0, 6));
        end else if (far_offset) begin
          append_random($urandom_range(0, 20));
        end else begin
          if (offset > body_end) append_random(offset - body_end);
          mag = height[31] ? -height : height;
          px_size = (bpp == BPP_32) ? 4 : 3;
          row_size = int'(width) * px_size + ((px_size == 3) ? int'(width[1:0]) : 0);
          pix_len = row_size * int'(mag);
          case (kind)
            F_TALL: append_random($urandom_range(0, 3 * row_size));
            // Only the start of the widest row is sent.
            F_WIDE: append_random($urandom_range(0, 400));
            F_TRUNC: begin
              total = bmp_image.size() + pix_len;
              cut = $urandom_range(0, total - 1);
              if (cut < bmp_image.size()) begin
                while (bmp_image.size() > cut) void'(bmp_image.pop_back());
              end else begin
                append_random(cut - bmp_image.size());
              end
            end
            default: begin
              append_random(pix_len);
              if ($urandom_range(0, 3) == 0) append_random($urandom_range(1, 3));
            end
          endcase
        end
      end
    end
    foreach (bmp_image[i]) queue_item(1'b0, bmp_image[i]);
    queue_item(1'b1, 8'($urandom));
    files_sent++;
    small_items += bmp_image.size() + 1;
  endtask

  // Reset, directed items, every file kind once, then random files.
  initial begin : stimulus
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.func      = 1'b0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    reset_parser();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // An empty stream, then a header whose first byte breaks the signature,
    // with bytes after the error that must be ignored, then another empty stream.
    queue_item(1'b1, 8'hFF);
    queue_item(1'b0, 8'h00);
    repeat (13) queue_item(1'b0, 8'hFF);
    queue_item(1'b0, 8'h00);
    queue_item(1'b0, 8'hFF);
    queue_item(1'b1, 8'h00);
    queue_item(1'b1, 8'h5A);
    wait_idle();

    for (int k = 0; k <= int'(F_NOISE); k++) send_file(file_kind_t'(k));
    // Let the sender sit idle until all of that has drained.
    wait_idle();

    while (small_items < RANDOM_ITEMS) send_file(pick_kind());

    wait_idle();
    repeat (10) @(posedge clk);

    $display("Sent %0d files in %0d items; checked %0d results: %0d pixels, %0d complete,",
             files_sent, accepted_count, results_seen, status_seen[ST_PIXEL],
             status_seen[ST_COMPLETE]);
    $display("%0d truncated and %0d rejected headers, with random idles on both sides.",
             status_seen[ST_TRUNCATED], results_seen - status_seen[ST_PIXEL]
             - status_seen[ST_COMPLETE] - status_seen[ST_TRUNCATED]);
    if (error_count == 0) begin
      $display("bmp_stream_pixel_decoder verification clean");
    end else begin
      $display("bmp_stream_pixel_decoder verification failed");
    end
    $finish;
  end

endmodule

### bmp_stream_pixel_decoder.f
+incdir+src
src/bmp_dec_pkg.sv
src/bmp_dec_if.sv
src/bmp_dec_core.sv
src/bmp_dec_obuf.sv
src/bmp_stream_pixel_decoder.sv
test/bmp_stream_pixel_decoder_tb.sv
